### rtl/pots_pkg.sv
`default_nettype none

package pots_pkg;

    typedef logic [2:0] status_t;

    localparam status_t STATUS_IDLE      = 3'd0;
    localparam status_t STATUS_MEASURING = 3'd1;
    localparam status_t STATUS_APPLY     = 3'd2;
    localparam status_t STATUS_FINISHED  = 3'd3;
    localparam status_t STATUS_ERROR     = 3'd4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PULSE = 1'b1;

    localparam int SUM_W = 41;

    localparam logic [10:0] SAMPLES_RESET = 11'd256;
    localparam logic [10:0] MAX_SAMPLES   = 11'd1024;
    localparam logic [6:0]  START_STEP    = 7'd64;
    localparam logic [12:0] COUNT_MAX     = 13'd8191;

    localparam logic [30:0] NS_PER_SEC   = 31'd1000000000;
    localparam logic [30:0] NS_LATE_MAX  = 31'd100000000;
    localparam logic [30:0] NS_EARLY_MIN = 31'd900000000;

    // one second plus one nanosecond, per averaged sample
    localparam logic [SUM_W-1:0] THR_UNIT = 41'd1000000001;

endpackage

`default_nettype wire

### rtl/pps_oscillator_trim_search.sv
`default_nettype none

// an accepted word sits in the input register, and its result moves on to the result register
// throughput: one word per cycle; the input register takes a new word whenever the
//   result register is empty or being drained in the same cycle
// reset: aresetn is synchronous and active low; it clears the search (idle, trim 0,
//   step 64, counters 0), empties both registers and sets samples_per_trial to 256
module pps_oscillator_trim_search import pots_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [31:0] s_pulse_seq,
    input  wire logic [31:0] s_pulse_sec,
    input  wire logic [29:0] s_pulse_nsec,

    output logic             m_valid,
    input  wire logic        m_ready,
    output status_t          m_status,
    output logic signed [7:0] m_trim_value,
    output logic [12:0]      m_pulses_elapsed
);

    // configuration and the per-round threshold derived from it
    logic [10:0]      cfg_reg;
    logic [10:0]      need;
    logic [SUM_W-1:0] thr_reg;

    // input register
    logic        in_valid_reg;
    logic        in_type_reg;
    logic [31:0] in_seq_reg;
    logic [31:0] in_sec_reg;
    logic [29:0] in_nsec_reg;

    // search state
    logic              running_reg,  running_next;
    logic              await_reg,    await_next;
    logic signed [7:0] trim_reg,     trim_next;
    logic [6:0]        step_reg,     step_next;
    logic [31:0]       last_seq_reg, last_seq_next;
    logic [31:0]       last_sec_reg, last_sec_next;
    logic [29:0]       last_nsec_reg, last_nsec_next;
    logic [SUM_W-1:0]  sum_reg,      sum_next;
    logic [10:0]       taken_reg,    taken_next;
    logic [12:0]       count_reg,    count_next;
    status_t           status_next;

    // result register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic signed [7:0] out_trim_reg;
    logic [12:0]       out_count_reg;

    logic fire;

    // pulse checks
    logic             seq_ok;
    logic             sec_lt;
    logic [31:0]      dsec;
    logic             dsec_big;
    logic             nsec_lt;
    logic [30:0]      diff_ns;
    logic [30:0]      dns;
    logic             whole_sec;
    logic             early_err;
    logic             window_err;
    logic [SUM_W-1:0] interval;
    logic [SUM_W-1:0] sum_add;
    logic [10:0]      taken_inc;
    logic             round_done;
    logic             slow;
    logic signed [7:0] step_s;
    logic [12:0]      count_inc;

    // effective sample count: zero reads as one, large values saturate
    function automatic logic [10:0] eff_samples(input logic [10:0] value);
        logic [10:0] n;
        if (value == 11'd0) begin
            n = 11'd1;
        end else if (value > MAX_SAMPLES) begin
            n = MAX_SAMPLES;
        end else begin
            n = value;
        end
        return n;
    endfunction

    // the result side moves when its register is free or drained this cycle
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign need = eff_samples(cfg_reg);

    // interval arithmetic, kept to 31 bits since nanoseconds stay under 2^30
    assign seq_ok   = (in_seq_reg == last_seq_reg + 32'd1);
    assign sec_lt   = (in_sec_reg < last_sec_reg);
    assign dsec     = in_sec_reg - last_sec_reg;
    assign dsec_big = |dsec[31:1];
    assign nsec_lt  = (in_nsec_reg < last_nsec_reg);
    assign diff_ns  = {1'b0, in_nsec_reg} - {1'b0, last_nsec_reg};
    // a borrow across the second boundary adds one second back in
    assign dns      = nsec_lt ? diff_ns + NS_PER_SEC : diff_ns;
    // one full second elapsed and no borrow: the interval is 1 s plus dns
    assign whole_sec = dsec[0] && !nsec_lt;

    assign early_err  = !seq_ok || sec_lt || dsec_big || (nsec_lt && !dsec[0]);
    assign window_err = whole_sec ? (dns > NS_LATE_MAX) : (dns < NS_EARLY_MIN);

    // a borrow from a last time past one second leaves dns below zero; bit 30 is
    // then its sign, so a wrapped sum lands far above any threshold
    assign interval   = (whole_sec ? SUM_W'(NS_PER_SEC) : '0)
                        + {{(SUM_W-31){dns[30]}}, dns};
    assign sum_add    = sum_reg + interval;
    assign taken_inc  = taken_reg + 11'd1;
    assign round_done = (taken_inc >= need);
    // mean above one second means the oscillator runs slow relative to the trim
    assign slow       = (sum_add >= thr_reg);
    assign step_s     = $signed({1'b0, step_reg});
    assign count_inc  = (count_reg < COUNT_MAX) ? count_reg + 13'd1 : count_reg;

    always_comb begin
        running_next   = running_reg;
        await_next     = await_reg;
        trim_next      = trim_reg;
        step_next      = step_reg;
        last_seq_next  = last_seq_reg;
        last_sec_next  = last_sec_reg;
        last_nsec_next = last_nsec_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        count_next     = count_reg;
        status_next    = STATUS_IDLE;

        if (in_type_reg == REQ_START) begin
            // restart, also in the middle of a search
            running_next = 1'b1;
            await_next   = 1'b1;
            trim_next    = '0;
            step_next    = START_STEP;
            sum_next     = '0;
            taken_next   = '0;
            count_next   = '0;
            status_next  = STATUS_APPLY;
        end else if (running_reg) begin
            count_next = count_inc;
            if (await_reg) begin
                // reference pulse opens the round
                last_seq_next  = in_seq_reg;
                last_sec_next  = in_sec_reg;
                last_nsec_next = in_nsec_reg;
                await_next     = 1'b0;
                sum_next       = '0;
                taken_next     = '0;
                status_next    = STATUS_MEASURING;
            end else if (early_err) begin
                running_next = 1'b0;
                status_next  = STATUS_ERROR;
            end else begin
                last_seq_next  = in_seq_reg;
                last_sec_next  = in_sec_reg;
                last_nsec_next = in_nsec_reg;
                if (window_err) begin
                    running_next = 1'b0;
                    status_next  = STATUS_ERROR;
                end else if (!round_done) begin
                    sum_next    = sum_add;
                    taken_next  = taken_inc;
                    status_next = STATUS_MEASURING;
                end else begin
                    trim_next  = slow ? trim_reg - step_s : trim_reg + step_s;
                    step_next  = step_reg >> 1;
                    sum_next   = '0;
                    taken_next = '0;
                    await_next = 1'b1;
                    if (step_reg[6:1] == 6'd0) begin
                        // last step was one: search complete
                        running_next = 1'b0;
                        status_next  = STATUS_FINISHED;
                    end else begin
                        status_next = STATUS_APPLY;
                    end
                end
            end
        end
    end

    // threshold loads together with the register, so a word always sees a matching pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= SAMPLES_RESET;
            thr_reg <= THR_UNIT * SUM_W'(SAMPLES_RESET);
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
            thr_reg <= THR_UNIT * SUM_W'(eff_samples(cfg_wdata));
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg <= s_req_type;
            in_seq_reg  <= s_pulse_seq;
            in_sec_reg  <= s_pulse_sec;
            in_nsec_reg <= s_pulse_nsec;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_status_reg <= status_next;
            out_trim_reg   <= trim_next;
            out_count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            await_reg     <= 1'b1;
            trim_reg      <= '0;
            step_reg      <= START_STEP;
            last_seq_reg  <= '0;
            last_sec_reg  <= '0;
            last_nsec_reg <= '0;
            sum_reg       <= '0;
            taken_reg     <= '0;
            count_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (fire) begin
                running_reg   <= running_next;
                await_reg     <= await_next;
                trim_reg      <= trim_next;
                step_reg      <= step_next;
                last_seq_reg  <= last_seq_next;
                last_sec_reg  <= last_sec_next;
                last_nsec_reg <= last_nsec_next;
                sum_reg       <= sum_next;
                taken_reg     <= taken_next;
                count_reg     <= count_next;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_trim_value     = out_trim_reg;
    assign m_pulses_elapsed = out_count_reg;

endmodule

`default_nettype wire

### rtl/pots_checker.sv
`default_nettype none

module pots_checker import pots_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic [10:0] cfg_wdata,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_req_type,
    input wire logic [31:0] s_pulse_seq,
    input wire logic [31:0] s_pulse_sec,
    input wire logic [29:0] s_pulse_nsec,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic signed [7:0] m_trim_value,
    input wire logic [12:0] m_pulses_elapsed
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
            $stable(m_trim_value) && $stable(m_pulses_elapsed))
        else $error("result word changed while stalled");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // the last step is one, so a finished trim is always odd
    a_final_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_FINISHED |-> m_trim_value[0])
        else $error("finished trim is even");

    // measuring only follows a counted pulse
    a_meas_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_MEASURING |-> m_pulses_elapsed != 13'd0)
        else $error("measuring with no pulses counted");

endmodule

bind pps_oscillator_trim_search pots_checker u_pots_checker (.*);

`default_nettype wire
